@@ rtl/b32d_pkg.sv @@
`timescale 1ns / 1ps

package b32d_pkg;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK            = 3'd0;
  localparam status_t ST_BAD_CHAR      = 3'd1;
  localparam status_t ST_MISPLACED_PAD = 3'd2;
  localparam status_t ST_BAD_LENGTH    = 3'd3;
  localparam status_t ST_BAD_PAD_COUNT = 3'd4;
  localparam status_t ST_TAIL_BITS     = 3'd5;

  localparam logic [7:0] CHAR_PAD    = 8'h3D;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_Z      = 8'h5A;
  localparam logic [7:0] CHAR_TWO    = 8'h32;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;
  localparam logic [4:0] DIGIT_BASE  = 5'h1A;

  localparam int STORE_W = 12;
  localparam int COUNT_W = 4;
  localparam int PADS_W  = 4;
  localparam int GROUP_W = 3;

  typedef struct packed {
    logic       is_data;
    logic       is_pad;
    logic       is_bad;
    logic [4:0] value;
  } char_info_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done_res;
    status_t    status;
  } out_item_t;

endpackage

@@ rtl/b32d_if.sv @@
`timescale 1ns / 1ps

interface b32d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface b32d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       done_res;
  logic [2:0] status;

  modport source (output valid, output data_byte, output byte_valid, output done_res,
                  output status, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input done_res,
                  input status, output ready);
endinterface

@@ rtl/base32_stream_decoder.sv @@
// an input transfer is captured in the input register, then its result in the result register
// throughput: one character per cycle when the result side keeps ready high
// characters that finish no byte and are not last give no result and do not wait for the result side
// reset: synchronous active-low rst_n clears the pipeline valids and all decode state
`timescale 1ns / 1ps

module base32_stream_decoder
  import b32d_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  b32d_in_if.sink           in_ch,
  b32d_out_if.source        out_ch
);

  logic       in_v_r;
  logic [7:0] in_char_r;
  logic       in_last_r;
  logic       out_v_r, out_v_nxt;
  out_item_t  out_r;

  char_info_t info;
  out_item_t  item;
  logic       has_result;
  logic       out_free;
  logic       step;

  b32d_char_map u_map (
    .char_code (in_char_r),
    .info      (info)
  );

  b32d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .info       (info),
    .is_last    (in_last_r),
    .has_result (has_result),
    .item       (item)
  );

  assign out_free    = !out_v_r || out_ch.ready;
  assign step        = in_v_r && (!has_result || out_free);
  assign in_ch.ready = !in_v_r || step;

  always_comb begin
    out_v_nxt = out_v_r;
    if (step && has_result) out_v_nxt = 1'b1;
    else if (out_ch.ready)  out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) in_v_r <= in_ch.valid;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_char_r <= in_ch.char_code;
      in_last_r <= in_ch.is_last;
    end
    if (step && has_result) out_r <= item;
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.data_byte  = out_r.data_byte;
  assign out_ch.byte_valid = out_r.byte_valid;
  assign out_ch.done_res   = out_r.done_res;
  assign out_ch.status     = out_r.status;

endmodule

@@ rtl/b32d_char_map.sv @@
`timescale 1ns / 1ps

module b32d_char_map
  import b32d_pkg::*;
(
  input  logic [7:0] char_code,
  output char_info_t info
);

  logic [7:0] letter_off;
  logic [7:0] digit_off;

  assign letter_off = char_code - CHAR_A;
  assign digit_off  = char_code - CHAR_TWO;

  always_comb begin
    info = '0;
    if (char_code inside {[CHAR_A:CHAR_Z]}) begin
      info.is_data = 1'b1;
      info.value   = letter_off[4:0];
    end else if (char_code inside {[CHAR_TWO:CHAR_SEVEN]}) begin
      info.is_data = 1'b1;
      info.value   = DIGIT_BASE + digit_off[4:0];
    end else if (char_code == CHAR_PAD) begin
      info.is_pad = 1'b1;
    end else begin
      info.is_bad = 1'b1;
    end
  end

endmodule

@@ rtl/b32d_core.sv @@
`timescale 1ns / 1ps

module b32d_core
  import b32d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  char_info_t info,
  input  logic       is_last,
  output logic       has_result,
  output out_item_t  item
);

  logic [STORE_W-1:0] store_r, store_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PADS_W-1:0]  pads_r, pads_nxt;
  logic [GROUP_W-1:0] group_r, group_nxt;
  logic               padding_r, padding_nxt;
  status_t            err_r, err_nxt;

  logic [STORE_W-1:0] store_a;
  logic [STORE_W-1:0] tail_mask;
  logic [STORE_W-1:0] keep_mask;
  logic [STORE_W-1:0] shifted;
  logic [COUNT_W-1:0] count_a;
  logic [COUNT_W-1:0] count_b;
  logic [PADS_W-1:0]  pads_a;
  logic               padding_a;
  logic               have_byte;
  logic               pads_ok;
  status_t            err_a;

  always_comb begin
    store_a   = store_r;
    count_a   = count_r;
    pads_a    = pads_r;
    padding_a = padding_r;
    err_a     = err_r;
    tail_mask = (STORE_W'(1) << count_r[2:0]) - STORE_W'(1);

    if (info.is_data) begin
      if (padding_r && err_a == ST_OK) err_a = ST_MISPLACED_PAD;
      store_a = {store_r[STORE_W-6:0], info.value};
      count_a = count_r + COUNT_W'(5);
    end else if (info.is_pad) begin
      if (!padding_r) begin
        padding_a = 1'b1;
        if ((store_r & tail_mask) != '0 && err_a == ST_OK) err_a = ST_TAIL_BITS;
      end
      if (pads_r != {PADS_W{1'b1}}) pads_a = pads_r + PADS_W'(1);
    end else if (err_a == ST_OK) begin
      err_a = ST_BAD_CHAR;
    end

    have_byte = count_a >= COUNT_W'(8);
    count_b   = have_byte ? count_a - COUNT_W'(8) : count_a;
    shifted   = store_a >> count_b;
    keep_mask = (STORE_W'(1) << count_b) - STORE_W'(1);
    group_nxt = group_r + GROUP_W'(1);

    pads_ok = pads_a inside {4'd0, 4'd1, 4'd3, 4'd4, 4'd6};
    if (is_last) begin
      if (group_nxt != '0 && err_a == ST_OK) err_a = ST_BAD_LENGTH;
      if (!pads_ok && err_a == ST_OK) err_a = ST_BAD_PAD_COUNT;
    end

    has_result      = have_byte || is_last;
    item.data_byte  = have_byte ? shifted[7:0] : 8'd0;
    item.byte_valid = have_byte;
    item.done_res   = is_last;
    item.status     = err_a;

    // the last character ends the string, so the next one starts afresh
    if (is_last) begin
      store_nxt   = '0;
      count_nxt   = '0;
      pads_nxt    = '0;
      padding_nxt = 1'b0;
      err_nxt     = ST_OK;
      group_nxt   = '0;
    end else begin
      store_nxt   = have_byte ? (store_a & keep_mask) : store_a;
      count_nxt   = count_b;
      pads_nxt    = pads_a;
      padding_nxt = padding_a;
      err_nxt     = err_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r   <= '0;
      count_r   <= '0;
      pads_r    <= '0;
      group_r   <= '0;
      padding_r <= 1'b0;
      err_r     <= ST_OK;
    end else if (step) begin
      store_r   <= store_nxt;
      count_r   <= count_nxt;
      pads_r    <= pads_nxt;
      group_r   <= group_nxt;
      padding_r <= padding_nxt;
      err_r     <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_below_byte: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < COUNT_W'(8))
    else $error("bit count reached a full byte between transfers");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && is_last |=> group_r == '0 && err_r == ST_OK && pads_r == '0 && !padding_r)
    else $error("state not cleared after last character");

  a_pads_imply_padding: assert property (@(posedge clk) disable iff (!rst_n)
    pads_r != '0 |-> padding_r)
    else $error("pad count without padding flag");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    step && !is_last && err_r != ST_OK |=> err_r == $past(err_r))
    else $error("latched error changed within a string");
`endif

endmodule
